FILE: src/lmc_pkg.sv
// ----------------------------------------------------------------------------
// lmc_pkg
// Shared types and constants for the multichannel LMS canceller.
// ----------------------------------------------------------------------------
package lmc_pkg;

  // Width of every sample field on the channels
  localparam int FIELD_W = 16;
  // Default number of sample bits actually used
  localparam int SAMPLE_BITS_DEF = 16;
  // Auxiliary channels carried by one word (reference channel excluded)
  localparam int AUX_COUNT = 3;
  // Weight format Q16.32
  localparam int WEIGHT_W    = 48;
  localparam int WEIGHT_FRAC = 32;
  // Step shift register
  localparam int                   STEP_SHIFT_W   = 6;
  localparam logic [STEP_SHIFT_W-1:0] STEP_SHIFT_RST = STEP_SHIFT_W'(7);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_UPD,
    ST_WB
  } state_t;

  // Per-lane control from the sequencer
  typedef struct packed {
    logic load;    // capture auxiliary sample
    logic mul_en;  // weight times sample
    logic upd_en;  // error times sample
    logic wb_en;   // shift, add and write the weight back
  } lane_ctrl_t;

endpackage

FILE: src/lmc_in_if.sv
// ----------------------------------------------------------------------------
// lmc_in_if
// Input snapshot channel: reference sample and auxiliary samples.
// ----------------------------------------------------------------------------
interface lmc_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [lmc_pkg::FIELD_W-1:0] ref_sample;
  logic signed [lmc_pkg::FIELD_W-1:0] aux_sample_1;
  logic signed [lmc_pkg::FIELD_W-1:0] aux_sample_2;
  logic signed [lmc_pkg::FIELD_W-1:0] aux_sample_3;

  modport source (
    output valid, ref_sample, aux_sample_1, aux_sample_2, aux_sample_3,
    input  ready
  );
  modport sink (
    input  valid, ref_sample, aux_sample_1, aux_sample_2, aux_sample_3,
    output ready
  );
endinterface

FILE: src/lmc_out_if.sv
// ----------------------------------------------------------------------------
// lmc_out_if
// Result channel: canceller error sample and clip flag.
// ----------------------------------------------------------------------------
interface lmc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [lmc_pkg::FIELD_W-1:0] error_sample;
  logic                               saturated;

  modport source (
    output valid, error_sample, saturated,
    input  ready
  );
  modport sink (
    input  valid, error_sample, saturated,
    output ready
  );
endinterface

FILE: src/lmc_lane.sv
// ----------------------------------------------------------------------------
// lmc_lane
// One auxiliary channel: holds its weight, forms weight times sample for the
// merge, and applies the LMS update with the saturated error.
// ----------------------------------------------------------------------------
module lmc_lane #(
  parameter int SAMPLE_BITS = lmc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  lmc_pkg::lane_ctrl_t                  ctrl,
  input  logic signed [lmc_pkg::FIELD_W-1:0]   aux_field,
  input  logic signed [SAMPLE_BITS-1:0]        err,
  input  logic [lmc_pkg::STEP_SHIFT_W-1:0]     step_shift,
  output logic signed [lmc_pkg::WEIGHT_W+SAMPLE_BITS-1:0] prod
);

  localparam int PROD_W = lmc_pkg::WEIGHT_W + SAMPLE_BITS;
  localparam int UPD_W  = 2 * SAMPLE_BITS;
  localparam int ACC_W  = lmc_pkg::WEIGHT_W + 1;
  localparam logic signed [ACC_W-1:0] W_MAX =
    ACC_W'({1'b0, {(lmc_pkg::WEIGHT_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] W_MIN = -W_MAX - ACC_W'(1);

  logic signed [SAMPLE_BITS-1:0]       aux_r;
  logic signed [lmc_pkg::WEIGHT_W-1:0] weight_r, weight_nxt;
  logic signed [PROD_W-1:0]            prod_r;
  logic signed [UPD_W-1:0]             eprod_r;
  logic signed [UPD_W-1:0]             upd;
  logic signed [ACC_W-1:0]             acc;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      aux_r <= aux_field[SAMPLE_BITS-1:0];
    end
    if (ctrl.mul_en) begin
      prod_r <= weight_r * aux_r;
    end
    if (ctrl.upd_en) begin
      eprod_r <= err * aux_r;
    end
  end

  // floor shift, then saturating add to the weight
  always_comb begin
    upd = eprod_r >>> step_shift;
    acc = ACC_W'(weight_r) + ACC_W'(upd);
    if (acc > W_MAX) begin
      weight_nxt = W_MAX[lmc_pkg::WEIGHT_W-1:0];
    end else if (acc < W_MIN) begin
      weight_nxt = W_MIN[lmc_pkg::WEIGHT_W-1:0];
    end else begin
      weight_nxt = acc[lmc_pkg::WEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= '0;
    end else if (ctrl.wb_en) begin
      weight_r <= weight_nxt;
    end
  end

  assign prod = prod_r;

endmodule

FILE: src/lmc_merge.sv
// ----------------------------------------------------------------------------
// lmc_merge
// Sums the lane products, floors to an integer, subtracts from the reference
// and saturates. Holds the error that feeds the output and the lane updates.
// ----------------------------------------------------------------------------
module lmc_merge #(
  parameter int SAMPLE_BITS = lmc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          sum_en,
  input  logic signed [lmc_pkg::WEIGHT_W+SAMPLE_BITS-1:0] prod [lmc_pkg::AUX_COUNT],
  input  logic signed [SAMPLE_BITS-1:0] ref_val,
  output logic signed [SAMPLE_BITS-1:0] err,
  output logic                          sat
);

  localparam int PROD_W = lmc_pkg::WEIGHT_W + SAMPLE_BITS;
  localparam int SUM_W  = PROD_W + $clog2(lmc_pkg::AUX_COUNT + 1);
  localparam int HI_W   = SUM_W - lmc_pkg::WEIGHT_FRAC;
  localparam int ERR_W  = HI_W + 1;
  localparam logic signed [ERR_W-1:0] S_MAX = ERR_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ERR_W-1:0] S_MIN = -S_MAX - ERR_W'(1);

  logic signed [SUM_W-1:0]       acc;
  logic signed [HI_W-1:0]        whole;
  logic signed [ERR_W-1:0]       diff;
  logic signed [SAMPLE_BITS-1:0] err_r, err_nxt;
  logic                          sat_r, sat_nxt;

  always_comb begin
    acc = '0;
    for (int k = 0; k < lmc_pkg::AUX_COUNT; k++) begin
      acc = acc + SUM_W'(prod[k]);
    end
    // drop the fraction bits: floor toward minus infinity
    whole = acc[SUM_W-1:lmc_pkg::WEIGHT_FRAC];
    diff  = ERR_W'(ref_val) - ERR_W'(whole);
    if (diff > S_MAX) begin
      err_nxt = S_MAX[SAMPLE_BITS-1:0];
      sat_nxt = 1'b1;
    end else if (diff < S_MIN) begin
      err_nxt = S_MIN[SAMPLE_BITS-1:0];
      sat_nxt = 1'b1;
    end else begin
      err_nxt = diff[SAMPLE_BITS-1:0];
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_en) begin
      err_r <= err_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign err = err_r;
  assign sat = sat_r;

endmodule

FILE: src/lms_multichannel_canceller_core.sv
// ----------------------------------------------------------------------------
// lms_multichannel_canceller_core
// Multichannel LMS interference canceller, one snapshot word per item.
// ----------------------------------------------------------------------------
// Each input word carries a reference sample and three auxiliary samples; the
// block returns one word with the reference minus the weighted auxiliaries,
// saturated to SAMPLE_BITS, then updates each Q16.32 weight by
// (error * sample) >>> step_shift. Steps: weight multiply, merge and saturate,
// update multiply, weight write-back; the next word is taken in write-back,
// so a new word waits on the last one. The merge waits while an earlier
// result sits unread in the output register. step_shift resets to 7; the user
// must write it only while idle, as the block itself does not enforce this.
module lms_multichannel_canceller_core #(
  parameter int SAMPLE_BITS = lmc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  lmc_in_if.sink                            in_chan,
  lmc_out_if.source                         out_chan,
  input  logic                              cfg_we,
  input  logic [lmc_pkg::STEP_SHIFT_W-1:0]  cfg_wdata
);

  localparam int PROD_W = lmc_pkg::WEIGHT_W + SAMPLE_BITS;

  lmc_pkg::state_t    state_r, state_nxt;
  lmc_pkg::lane_ctrl_t lane_ctrl;
  logic               sum_en;
  logic               in_ready;
  logic               out_valid_r, out_valid_nxt;
  logic [lmc_pkg::STEP_SHIFT_W-1:0] step_shift_r;
  logic signed [SAMPLE_BITS-1:0]    ref_r;
  logic signed [SAMPLE_BITS-1:0]    err;
  logic                             sat;
  logic signed [lmc_pkg::FIELD_W-1:0] aux_field [lmc_pkg::AUX_COUNT];
  logic signed [PROD_W-1:0]           prod      [lmc_pkg::AUX_COUNT];

  assign aux_field[0] = in_chan.aux_sample_1;
  assign aux_field[1] = in_chan.aux_sample_2;
  assign aux_field[2] = in_chan.aux_sample_3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_shift_r <= lmc_pkg::STEP_SHIFT_RST;
    end else if (cfg_we) begin
      step_shift_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lmc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    lane_ctrl = '0;
    sum_en    = 1'b0;
    in_ready  = 1'b0;
    case (state_r)
      lmc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_chan.valid) begin
          lane_ctrl.load = 1'b1;
          state_nxt      = lmc_pkg::ST_MUL;
        end
      end
      lmc_pkg::ST_MUL: begin
        lane_ctrl.mul_en = 1'b1;
        state_nxt        = lmc_pkg::ST_SUM;
      end
      lmc_pkg::ST_SUM: begin
        // hold until the output register is free
        if (!out_valid_r || out_chan.ready) begin
          sum_en    = 1'b1;
          state_nxt = lmc_pkg::ST_UPD;
        end
      end
      lmc_pkg::ST_UPD: begin
        lane_ctrl.upd_en = 1'b1;
        state_nxt        = lmc_pkg::ST_WB;
      end
      lmc_pkg::ST_WB: begin
        lane_ctrl.wb_en = 1'b1;
        in_ready        = 1'b1;
        if (in_chan.valid) begin
          lane_ctrl.load = 1'b1;
          state_nxt      = lmc_pkg::ST_MUL;
        end else begin
          state_nxt = lmc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lmc_pkg::ST_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    if (sum_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lane_ctrl.load) begin
      ref_r <= in_chan.ref_sample[SAMPLE_BITS-1:0];
    end
  end

  for (genvar k = 0; k < lmc_pkg::AUX_COUNT; k++) begin : g_lane
    lmc_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (lane_ctrl),
      .aux_field  (aux_field[k]),
      .err        (err),
      .step_shift (step_shift_r),
      .prod       (prod[k])
    );
  end

  lmc_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk     (clk),
    .sum_en  (sum_en),
    .prod    (prod),
    .ref_val (ref_r),
    .err     (err),
    .sat     (sat)
  );

  assign in_chan.ready         = in_ready;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.error_sample = lmc_pkg::FIELD_W'(err);
  assign out_chan.saturated    = sat;

endmodule

FILE: src/lmc_checker.sv
// ----------------------------------------------------------------------------
// lmc_checker
// Port-level checks for the canceller core, bound to the top level.
// ----------------------------------------------------------------------------
module lmc_checker #(
  parameter int SAMPLE_BITS = lmc_pkg::SAMPLE_BITS_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [lmc_pkg::FIELD_W-1:0] error_sample,
  input logic                               saturated
);

  localparam logic signed [lmc_pkg::FIELD_W-1:0] S_MAX =
    lmc_pkg::FIELD_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [lmc_pkg::FIELD_W-1:0] S_MIN = -S_MAX - lmc_pkg::FIELD_W'(1);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a result word stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(error_sample) && $stable(saturated))
    else $error("stalled result word changed");

  // the weight loop keeps the input closed right after a word is taken
  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input word taken while the weight loop is busy");

  // a fresh result follows its accepted word through the multiply and merge states
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc, 3))
    else $error("result word without a matching input word");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && saturated |-> (error_sample == S_MAX) || (error_sample == S_MIN))
    else $error("clip flag set on an unclipped error");

endmodule

bind lms_multichannel_canceller_core lmc_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_lmc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .error_sample (out_chan.error_sample),
  .saturated    (out_chan.saturated)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multichannel LMS canceller core. Snapshot words
// are pushed through a valid/ready driver, every accepted word is run through
// a bit-exact canceller model that keeps its own Q16.32 weights and step
// shift, and each returned word is compared against the oldest prediction.
// Stimulus: a few directed corner words, then adaptive phases where the
// reference is a weighted mix of the auxiliaries, mixed with raw noise.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_WORDS   = 130;
  localparam int PHASE_COUNT   = 12;

  localparam logic signed [63:0] W_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] W_MIN = -W_MAX - 64'sd1;
  localparam logic signed [67:0] E_MAX = 68'sd32767;
  localparam logic signed [67:0] E_MIN = -68'sd32768;
  localparam logic signed [15:0] S_MAX = 16'sh7FFF;
  localparam logic signed [15:0] S_MIN = 16'sh8000;

  typedef struct {
    logic signed [lmc_pkg::FIELD_W-1:0] ref_s;
    logic signed [lmc_pkg::FIELD_W-1:0] aux1;
    logic signed [lmc_pkg::FIELD_W-1:0] aux2;
    logic signed [lmc_pkg::FIELD_W-1:0] aux3;
  } snapshot_t;

  typedef struct {
    logic signed [lmc_pkg::FIELD_W-1:0] err;
    logic                               sat;
  } cancel_out_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [lmc_pkg::STEP_SHIFT_W-1:0] cfg_wdata;

  lmc_in_if  in_if ();
  lmc_out_if out_if ();

  lms_multichannel_canceller_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  snapshot_t   snap_q [$];
  cancel_out_t err_q [$];

  // canceller model state
  logic signed [lmc_pkg::WEIGHT_W-1:0] tap_w [lmc_pkg::AUX_COUNT];
  logic [lmc_pkg::STEP_SHIFT_W-1:0]    model_shift;

  // phase shaping of the adaptive stimulus
  int  mix_gain [lmc_pkg::AUX_COUNT];
  int  amp_bits;
  bit  calm;

  int  fail_cnt;
  int  cycle_cnt;
  bit  in_taken;

  function automatic bit idle_roll();
    return !calm && ($urandom_range(99) < 13);
  endfunction

  // Compute the error word for one snapshot and adapt the weights.
  function automatic cancel_out_t cancel_and_adapt(snapshot_t s);
    logic signed [lmc_pkg::FIELD_W-1:0] x [lmc_pkg::AUX_COUNT];
    logic signed [67:0]                 acc;
    logic signed [67:0]                 diff;
    logic signed [63:0]                 prod;
    logic signed [63:0]                 nw;
    cancel_out_t                        r;
    x[0] = s.aux1;
    x[1] = s.aux2;
    x[2] = s.aux3;
    acc = '0;
    for (int k = 0; k < lmc_pkg::AUX_COUNT; k++) begin
      acc = acc + tap_w[k] * x[k];
    end
    diff = s.ref_s - (acc >>> lmc_pkg::WEIGHT_FRAC);
    r.sat = 1'b0;
    if (diff > E_MAX) begin
      diff = E_MAX;
      r.sat = 1'b1;
    end else if (diff < E_MIN) begin
      diff = E_MIN;
      r.sat = 1'b1;
    end
    r.err = diff[lmc_pkg::FIELD_W-1:0];
    for (int k = 0; k < lmc_pkg::AUX_COUNT; k++) begin
      prod = r.err * x[k];
      nw = tap_w[k] + (prod >>> model_shift);
      if (nw > W_MAX) nw = W_MAX;
      if (nw < W_MIN) nw = W_MIN;
      tap_w[k] = nw[lmc_pkg::WEIGHT_W-1:0];
    end
    return r;
  endfunction

  // Reference built from the phase mix plus a little noise; some raw noise words.
  function automatic snapshot_t shaped_snap();
    snapshot_t s;
    int        a [lmc_pkg::AUX_COUNT];
    int        span;
    int        acc;
    if ($urandom_range(99) < 15) begin
      s.ref_s = 16'($urandom);
      s.aux1  = 16'($urandom);
      s.aux2  = 16'($urandom);
      s.aux3  = 16'($urandom);
    end else begin
      span = 1 << amp_bits;
      acc = int'($urandom_range(8)) - 4;
      for (int k = 0; k < lmc_pkg::AUX_COUNT; k++) begin
        a[k] = int'($urandom_range(span - 1)) - span / 2;
        acc = acc + ((mix_gain[k] * a[k]) >>> 2);
      end
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      s.ref_s = 16'(acc);
      s.aux1  = 16'(a[0]);
      s.aux2  = 16'(a[1]);
      s.aux3  = 16'(a[2]);
    end
    return s;
  endfunction

  task automatic push_snap(logic signed [15:0] r, logic signed [15:0] a1,
                           logic signed [15:0] a2, logic signed [15:0] a3);
    snapshot_t s;
    s.ref_s = r;
    s.aux1  = a1;
    s.aux2  = a2;
    s.aux3  = a3;
    snap_q.push_back(s);
  endtask

  // Hold until every word is sent and answered, then let the weight loop finish.
  task automatic settle();
    while (snap_q.size() != 0 || in_if.valid || err_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_shift(logic [lmc_pkg::STEP_SHIFT_W-1:0] v);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Driver: change inputs on the falling edge.
  always @(negedge clk) begin : feed_drv
    snapshot_t nxt;
    if (rst_n) begin
      if (!in_if.valid || in_taken) begin
        if (snap_q.size() != 0 && !idle_roll()) begin
          nxt = snap_q.pop_front();
          in_if.valid        <= 1'b1;
          in_if.ref_sample   <= nxt.ref_s;
          in_if.aux_sample_1 <= nxt.aux1;
          in_if.aux_sample_2 <= nxt.aux2;
          in_if.aux_sample_3 <= nxt.aux3;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= !idle_roll();
    end
  end

  // Monitor: sample on the rising edge, predict on input words, check output words.
  always @(posedge clk) begin : watch_mon
    snapshot_t   got_in;
    cancel_out_t want;
    in_taken <= in_if.valid && in_if.ready;
    if (rst_n) begin
      if (cfg_we) model_shift = cfg_wdata;
      if (in_if.valid && in_if.ready) begin
        got_in.ref_s = in_if.ref_sample;
        got_in.aux1  = in_if.aux_sample_1;
        got_in.aux2  = in_if.aux_sample_2;
        got_in.aux3  = in_if.aux_sample_3;
        err_q.push_back(cancel_and_adapt(got_in));
      end
      if (out_if.valid && out_if.ready) begin
        if (err_q.size() == 0) begin
          if (fail_cnt < 10) begin
            $display("unexpected word: error_sample %0d saturated %0b",
                     out_if.error_sample, out_if.saturated);
          end
          fail_cnt++;
        end else begin
          want = err_q.pop_front();
          if (want.err !== out_if.error_sample || want.sat !== out_if.saturated) begin
            if (fail_cnt < 10) begin
              $display("mismatch: error_sample exp %0d got %0d, saturated exp %0b got %0b",
                       want.err, out_if.error_sample, want.sat, out_if.saturated);
            end
            fail_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    int unsigned shift_plan [PHASE_COUNT];
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_if.valid        = 1'b0;
    in_if.ref_sample   = '0;
    in_if.aux_sample_1 = '0;
    in_if.aux_sample_2 = '0;
    in_if.aux_sample_3 = '0;
    out_if.ready       = 1'b0;
    in_taken           = 1'b0;
    fail_cnt           = 0;
    cycle_cnt          = 0;
    calm               = 1'b0;
    amp_bits           = 12;
    model_shift        = lmc_pkg::STEP_SHIFT_RST;
    for (int k = 0; k < lmc_pkg::AUX_COUNT; k++) begin
      tap_w[k]    = '0;
      mix_gain[k] = 0;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // corner words at the reset step shift
    push_snap(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    push_snap(S_MAX, 16'sd0, 16'sd0, 16'sd0);
    push_snap(S_MIN, 16'sd0, 16'sd0, 16'sd0);
    push_snap(S_MAX, S_MAX, S_MAX, S_MAX);
    push_snap(S_MIN, S_MIN, S_MIN, S_MIN);
    push_snap(S_MAX, S_MIN, S_MAX, S_MIN);
    push_snap(S_MIN, S_MAX, S_MIN, S_MAX);
    push_snap(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
    push_snap(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555);

    // widest shift: a negative update floors to minus one
    write_shift(6'd63);
    push_snap(-16'sd5, 16'sd1, 16'sd1, 16'sd1);
    push_snap(16'sd5, 16'sd1, -16'sd1, 16'sd1);
    push_snap(S_MIN, S_MAX, S_MIN, 16'sd1);

    // no shift: drive the weights hard until the error clips
    write_shift(6'd0);
    push_snap(S_MAX, S_MIN, S_MIN, S_MIN);
    push_snap(S_MAX, S_MIN, S_MIN, S_MIN);
    push_snap(S_MAX, S_MIN, S_MIN, S_MIN);
    push_snap(S_MIN, S_MAX, S_MAX, S_MAX);
    push_snap(S_MAX, S_MAX, S_MAX, S_MAX);
    push_snap(S_MAX, S_MAX, S_MAX, S_MAX);
    push_snap(S_MIN, S_MIN, S_MIN, S_MIN);
    push_snap(16'sd0, 16'sd1, -16'sd1, S_MIN);

    // adaptive phases; small shifts adapt at full scale, a few wide ones nearly freeze
    shift_plan = '{0, 2, 1, 63, 3, 0, 9, 1, 40, 4, 2, 0};
    shift_plan[6] = $urandom_range(63);
    shift_plan[9] = $urandom_range(8);
    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_shift(shift_plan[p][lmc_pkg::STEP_SHIFT_W-1:0]);
      calm = (p == 4);
      amp_bits = (p % 4 == 3) ? $urandom_range(15, 8) : $urandom_range(13, 11);
      for (int k = 0; k < lmc_pkg::AUX_COUNT; k++) begin
        mix_gain[k] = int'($urandom_range(8)) - 4;
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        snap_q.push_back(shaped_snap());
      end
    end

    settle();
    calm = 1'b0;
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    fail_cnt = fail_cnt + err_q.size();
    if (fail_cnt == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/lmc_pkg.sv
src/lmc_in_if.sv
src/lmc_out_if.sv
src/lmc_lane.sv
src/lmc_merge.sv
src/lms_multichannel_canceller_core.sv
src/lmc_checker.sv
tb/testbench.sv
